// ===== rtl/core/jsu_pkg.sv =====
// Shared types, codes and helper functions for the JSON string unescape block.
package jsu_pkg;

  localparam int unsigned MaxRes = 4;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_CTRL     = 3'd1,
    ERR_UNTERM   = 3'd2,
    ERR_ESCAPE   = 3'd3,
    ERR_HEX      = 3'd4,
    ERR_NO_LOW   = 3'd5,
    ERR_BAD_LOW  = 3'd6,
    ERR_LONE_LOW = 3'd7
  } err_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // All results caused by one input byte.
  typedef struct packed {
    logic [2:0]            cnt;    // 0..4 results
    kind_t                 kind;
    err_t                  err;
    logic [MaxRes-1:0][7:0] bytes; // bytes[0] goes out first
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // {valid, value} of an ASCII hex digit.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic bundle_t one_result(input kind_t k, input err_t e, input logic [7:0] b);
    bundle_t r;
    r = '0;
    r.cnt = 3'd1;
    r.kind = k;
    r.err = e;
    r.bytes[0] = b;
    return r;
  endfunction

  // UTF-8 encode a code point up to 21 bits.
  function automatic bundle_t utf8_encode(input logic [20:0] cp);
    bundle_t r;
    r = '0;
    r.kind = KIND_DATA;
    r.err = ERR_NONE;
    if (cp <= 21'h7F) begin
      r.cnt = 3'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      r.cnt = 3'd2;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      r.cnt = 3'd3;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.cnt = 3'd4;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/jsu_decode.sv =====
// Escape decoder: mode state and the per-byte result bundle.
module jsu_decode import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] in_byte,
  input  logic       in_new_string,
  output bundle_t    bnd
);

  typedef enum logic [2:0] {
    M_NORMAL  = 3'd0,
    M_ESCAPE  = 3'd1,
    M_HEX_A   = 3'd2,
    M_NEED_BS = 3'd3,
    M_NEED_U  = 3'd4,
    M_HEX_B   = 3'd5,
    M_HALTED  = 3'd6
  } mode_t;

  mode_t       mode_r, mode_nxt, mode_eff;
  logic [1:0]  cnt_r, cnt_nxt, cnt_eff;
  logic [15:0] acc_r, acc_nxt, acc_eff, acc_new;
  logic [9:0]  hi_r, hi_nxt, hi_eff;
  logic [4:0]  hx;
  logic [20:0] cp_pair;

  always_comb begin
    mode_eff = in_new_string ? M_NORMAL : mode_r;
    cnt_eff  = in_new_string ? 2'd0 : cnt_r;
    acc_eff  = in_new_string ? 16'd0 : acc_r;
    hi_eff   = in_new_string ? 10'd0 : hi_r;
    hx       = hex_decode(in_byte);
    acc_new  = {acc_eff[11:0], hx[3:0]};
    cp_pair  = 21'h10000 + {1'b0, hi_eff, acc_new[9:0]};

    mode_nxt = mode_eff;
    cnt_nxt  = cnt_eff;
    acc_nxt  = acc_eff;
    hi_nxt   = hi_eff;
    bnd      = '0;

    if (mode_eff == M_HALTED) begin
      bnd = '0;
    end else if (in_byte == 8'h00) begin
      bnd = one_result(KIND_ERROR, ERR_UNTERM, 8'h00);
      mode_nxt = M_HALTED;
    end else begin
      case (mode_eff)
        M_NORMAL: begin
          if (in_byte == CH_QUOTE) begin
            bnd = one_result(KIND_END, ERR_NONE, 8'h00);
            mode_nxt = M_HALTED;
          end else if (in_byte < CH_SPACE) begin
            bnd = one_result(KIND_ERROR, ERR_CTRL, 8'h00);
            mode_nxt = M_HALTED;
          end else if (in_byte == CH_BSLASH) begin
            mode_nxt = M_ESCAPE;
          end else begin
            bnd = one_result(KIND_DATA, ERR_NONE, in_byte);
          end
        end
        M_ESCAPE: begin
          mode_nxt = M_NORMAL;
          case (in_byte)
            CH_QUOTE:  bnd = one_result(KIND_DATA, ERR_NONE, CH_QUOTE);
            CH_BSLASH: bnd = one_result(KIND_DATA, ERR_NONE, CH_BSLASH);
            CH_SLASH:  bnd = one_result(KIND_DATA, ERR_NONE, CH_SLASH);
            CH_B:      bnd = one_result(KIND_DATA, ERR_NONE, 8'h08);
            CH_F:      bnd = one_result(KIND_DATA, ERR_NONE, 8'h0C);
            CH_N:      bnd = one_result(KIND_DATA, ERR_NONE, 8'h0A);
            CH_R:      bnd = one_result(KIND_DATA, ERR_NONE, 8'h0D);
            CH_T:      bnd = one_result(KIND_DATA, ERR_NONE, 8'h09);
            CH_U: begin
              cnt_nxt  = 2'd0;
              acc_nxt  = 16'd0;
              mode_nxt = M_HEX_A;
            end
            default: begin
              bnd = one_result(KIND_ERROR, ERR_ESCAPE, 8'h00);
              mode_nxt = M_HALTED;
            end
          endcase
        end
        M_HEX_A, M_HEX_B: begin
          if (!hx[4]) begin
            bnd = one_result(KIND_ERROR, ERR_HEX, 8'h00);
            mode_nxt = M_HALTED;
          end else begin
            acc_nxt = acc_new;
            if (cnt_eff != 2'd3) begin
              cnt_nxt = cnt_eff + 2'd1;
            end else begin
              cnt_nxt = 2'd0;
              if (mode_eff == M_HEX_A) begin
                if (acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
                  hi_nxt   = acc_new[9:0];
                  mode_nxt = M_NEED_BS;
                end else if (acc_new >= 16'hDC00 && acc_new <= 16'hDFFF) begin
                  bnd = one_result(KIND_ERROR, ERR_LONE_LOW, 8'h00);
                  mode_nxt = M_HALTED;
                end else begin
                  bnd = utf8_encode({5'd0, acc_new});
                  mode_nxt = M_NORMAL;
                end
              end else begin
                if (acc_new < 16'hDC00 || acc_new > 16'hDFFF) begin
                  bnd = one_result(KIND_ERROR, ERR_BAD_LOW, 8'h00);
                  mode_nxt = M_HALTED;
                end else begin
                  bnd = utf8_encode(cp_pair);
                  mode_nxt = M_NORMAL;
                end
              end
            end
          end
        end
        M_NEED_BS: begin
          if (in_byte != CH_BSLASH) begin
            bnd = one_result(KIND_ERROR, ERR_NO_LOW, 8'h00);
            mode_nxt = M_HALTED;
          end else begin
            mode_nxt = M_NEED_U;
          end
        end
        M_NEED_U: begin
          if (in_byte != CH_U) begin
            bnd = one_result(KIND_ERROR, ERR_NO_LOW, 8'h00);
            mode_nxt = M_HALTED;
          end else begin
            cnt_nxt  = 2'd0;
            acc_nxt  = 16'd0;
            mode_nxt = M_HEX_B;
          end
        end
        default: begin
          bnd = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NORMAL;
      cnt_r  <= 2'd0;
      acc_r  <= 16'd0;
      hi_r   <= 10'd0;
    end else if (step) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      hi_r   <= hi_nxt;
    end
  end

endmodule

// ===== rtl/core/jsu_result_queue.sv =====
// Result bundle queue and serializer onto the one-byte result channel.
module jsu_result_queue import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  bundle_t    push_bnd,
  output q_status_t  status,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [2:0] out_error_code,
  output logic       out_last
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  bundle_t           bq_r [Depth];
  logic [PtrW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PtrW:0]     cnt_r, cnt_nxt;
  logic [1:0]        idx_r, idx_nxt;
  bundle_t           head;
  logic              pop;

  assign head           = bq_r[rd_r];
  assign out_valid      = (cnt_r != '0);
  assign out_kind       = head.kind;
  assign out_byte       = head.bytes[idx_r];
  assign out_error_code = head.err;
  assign out_last       = ({1'b0, idx_r} == (head.cnt - 3'd1));
  assign pop            = out_valid && out_ready && out_last;
  assign status.full    = (cnt_r == (PtrW+1)'(Depth));
  assign status.empty   = (cnt_r == '0);

  always_comb begin
    wr_nxt  = push ? wr_r + PtrW'(1) : wr_r;
    rd_nxt  = pop ? rd_r + PtrW'(1) : rd_r;
    cnt_nxt = cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    idx_nxt = idx_r;
    if (out_valid && out_ready) begin
      idx_nxt = out_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
      idx_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      bq_r[wr_r] <= push_bnd;
    end
  end

endmodule

// ===== rtl/core/json_string_unescape_utf8.sv =====
// Top level of the JSON string unescaper with UTF-8 output.
//
// Input channel: one raw string-content byte per request (in_byte), taken
// after the opening quote; in_new_string marks the first byte of a new
// string and clears all decode state before that byte is judged.
// Result channel: one result per request: a decoded UTF-8 byte, an end
// marker or an error code; out_last flags the final result of an input byte.
// A byte may cause no result (backslash, hex digits) or up to four results
// (a joined surrogate pair).
// Path: a byte is held in the input register, is decoded and its results
// are written into a four-entry bundle queue that drives the result port.
// Throughput: one input byte per cycle while each byte gives at most one
// result and out_ready is high; the result port drains one byte per cycle
// while out_ready is high, so multi-byte bundles are absorbed by the queue.
// Stall: when out_ready is low, results hold and the queue fills; once the
// queue is full, a held byte that yields results stays in the input
// register and in_ready drops.
// Reset (rst_n low, synchronous): clears decode mode, queue and the input
// register's valid flag; no result is pending afterwards.
module json_string_unescape_utf8 import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_new_string,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [2:0] out_error_code,
  output logic       out_last
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_new_r;
  logic       adv;
  logic       push;
  bundle_t    bnd;
  q_status_t  qst;

  // Advance the held byte when its bundle fits, or when it yields nothing.
  assign adv      = s1_valid_r && (!qst.full || (bnd.cnt == 3'd0));
  assign push     = adv && (bnd.cnt != 3'd0);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // Payload: capture on accept only.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
      s1_new_r  <= in_new_string;
    end
  end

  jsu_decode u_dec (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (adv),
    .in_byte       (s1_byte_r),
    .in_new_string (s1_new_r),
    .bnd           (bnd)
  );

  jsu_result_queue u_q (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .push_bnd       (bnd),
    .status         (qst),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

`ifndef SYNTHESIS
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qst.full)
    else $error("bundle pushed into a full queue");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_DATA) |-> out_last)
    else $error("end or error result not flagged last");

  a_err_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_ERROR) |-> (out_error_code == ERR_NONE))
    else $error("error code on a non-error result");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("result pending or input blocked after reset");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
module tb_top import jsu_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Decoder states of the prediction; they mirror how far an escape has come.
  typedef enum logic [2:0] {
    M_PLAIN,    // ordinary characters
    M_ESC,      // backslash seen
    M_HEX_HI,   // digits of the first \u escape
    M_WANT_BS,  // high surrogate held, backslash must follow
    M_WANT_U,   // high surrogate held, u must follow
    M_HEX_LO,   // digits of the low surrogate escape
    M_DONE      // string ended or failed; drop bytes until a new string
  } scan_mode_t;

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    err_t       err;
    logic       last;
  } decoded_t;

  // Predicts the results of every accepted request and checks the result
  // stream against them in order.
  class unescape_scoreboard;
    scan_mode_t  mode;
    logic [1:0]  ndig;
    logic [15:0] acc;
    logic [9:0]  hi_bits;
    decoded_t    burst[$];
    decoded_t    pending_results[$];
    int          fails;

    function new();
      reset_state();
      fails = 0;
    endfunction

    function void reset_state();
      mode = M_PLAIN;
      ndig = 2'd0;
      acc = 16'h0000;
      hi_bits = 10'd0;
    endfunction

    function int hex_val(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
      return -1;
    endfunction

    function void emit(kind_t k, logic [7:0] b, err_t e);
      decoded_t r;
      r.kind = k;
      r.data = b;
      r.err = e;
      r.last = 1'b0;
      burst.push_back(r);
    endfunction

    function void halt(err_t e);
      emit(KIND_ERROR, 8'h00, e);
      mode = M_DONE;
    endfunction

    function void encode(logic [20:0] cp);
      if (cp <= 21'h7F) begin
        emit(KIND_DATA, cp[7:0], ERR_NONE);
      end else if (cp <= 21'h7FF) begin
        emit(KIND_DATA, 8'hC0 | 8'(cp >> 6), ERR_NONE);
        emit(KIND_DATA, 8'h80 | 8'(cp & 21'h3F), ERR_NONE);
      end else if (cp <= 21'hFFFF) begin
        emit(KIND_DATA, 8'hE0 | 8'(cp >> 12), ERR_NONE);
        emit(KIND_DATA, 8'h80 | 8'((cp >> 6) & 21'h3F), ERR_NONE);
        emit(KIND_DATA, 8'h80 | 8'(cp & 21'h3F), ERR_NONE);
      end else begin
        emit(KIND_DATA, 8'hF0 | 8'((cp >> 18) & 21'h07), ERR_NONE);
        emit(KIND_DATA, 8'h80 | 8'((cp >> 12) & 21'h3F), ERR_NONE);
        emit(KIND_DATA, 8'h80 | 8'((cp >> 6) & 21'h3F), ERR_NONE);
        emit(KIND_DATA, 8'h80 | 8'(cp & 21'h3F), ERR_NONE);
      end
    endfunction

    // Shift in one digit; true once the fourth one is in.
    function bit take_digit(int d);
      acc = {acc[11:0], 4'(d)};
      if (ndig == 2'd3) begin
        ndig = 2'd0;
        return 1'b1;
      end
      ndig = ndig + 2'd1;
      return 1'b0;
    endfunction

    function void note_request(logic [7:0] c, logic ns);
      int d;
      logic [20:0] cp;
      logic [7:0] lit;
      bit esc_ok;
      burst.delete();
      if (ns) reset_state();
      if (mode != M_DONE) begin
        if (c == 8'h00) begin
          halt(ERR_UNTERM);
        end else begin
          case (mode)
            M_PLAIN: begin
              if (c == CH_QUOTE) begin
                emit(KIND_END, 8'h00, ERR_NONE);
                mode = M_DONE;
              end else if (c < CH_SPACE) begin
                halt(ERR_CTRL);
              end else if (c == CH_BSLASH) begin
                mode = M_ESC;
              end else begin
                emit(KIND_DATA, c, ERR_NONE);
              end
            end
            M_ESC: begin
              esc_ok = 1'b1;
              lit = c;
              case (c)
                CH_QUOTE, CH_BSLASH, CH_SLASH: lit = c;
                CH_B: lit = 8'h08;
                CH_F: lit = 8'h0C;
                CH_N: lit = 8'h0A;
                CH_R: lit = 8'h0D;
                CH_T: lit = 8'h09;
                CH_U: begin
                  esc_ok = 1'b0;
                  ndig = 2'd0;
                  acc = 16'h0000;
                  mode = M_HEX_HI;
                end
                default: begin
                  esc_ok = 1'b0;
                  halt(ERR_ESCAPE);
                end
              endcase
              if (esc_ok) begin
                mode = M_PLAIN;
                emit(KIND_DATA, lit, ERR_NONE);
              end
            end
            M_HEX_HI: begin
              d = hex_val(c);
              if (d < 0) begin
                halt(ERR_HEX);
              end else if (take_digit(d)) begin
                if (acc >= 16'hD800 && acc <= 16'hDBFF) begin
                  hi_bits = 10'(acc - 16'hD800);
                  mode = M_WANT_BS;
                end else if (acc >= 16'hDC00 && acc <= 16'hDFFF) begin
                  halt(ERR_LONE_LOW);
                end else begin
                  mode = M_PLAIN;
                  encode({5'd0, acc});
                end
              end
            end
            M_WANT_BS: begin
              if (c != CH_BSLASH) halt(ERR_NO_LOW);
              else mode = M_WANT_U;
            end
            M_WANT_U: begin
              if (c != CH_U) begin
                halt(ERR_NO_LOW);
              end else begin
                ndig = 2'd0;
                acc = 16'h0000;
                mode = M_HEX_LO;
              end
            end
            M_HEX_LO: begin
              d = hex_val(c);
              if (d < 0) begin
                halt(ERR_HEX);
              end else if (take_digit(d)) begin
                if (acc < 16'hDC00 || acc > 16'hDFFF) begin
                  halt(ERR_BAD_LOW);
                end else begin
                  cp = 21'h10000 + {1'b0, hi_bits, acc[9:0]};
                  mode = M_PLAIN;
                  encode(cp);
                end
              end
            end
            default: ;
          endcase
        end
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) pending_results.push_back(burst[i]);
    endfunction

    function void mismatch(string field, logic [7:0] want, logic [7:0] got);
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      fails++;
    endfunction

    function void check_result(logic [1:0] k, logic [7:0] b, logic [2:0] e, logic l);
      decoded_t w;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: kind %0d byte %h error %0d last %b",
                 $time, k, b, e, l);
        fails++;
        return;
      end
      w = pending_results.pop_front();
      if (k !== w.kind) mismatch("kind", 8'(w.kind), 8'(k));
      if (b !== w.data) mismatch("byte", w.data, b);
      if (e !== w.err) mismatch("error_code", 8'(w.err), 8'(e));
      if (l !== w.last) mismatch("last", 8'(w.last), 8'(l));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_new_string = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [2:0] out_error_code;
  logic       out_last;

  unescape_scoreboard sb = new();

  bit         quiet = 1'b0;       // no idling on either side in the last part
  bit         long_hold = 1'b0;   // ask the receiver for one long stall
  bit         sender_idles = 1'b1;
  logic [7:0] text[$];            // bytes of the string about to be sent
  int         body_len;           // bytes of text that the block still decodes

  json_string_unescape_utf8 i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_new_string  (in_new_string),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

  always #6 clk = ~clk;

  // Both handshakes are sampled here, before the edge's updates land.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_request(in_byte, in_new_string);
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_kind, out_byte, out_error_code, out_last);
    end
  end

  // Receiver: random stalls, one long hold on request, none at the end.
  initial begin
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (80) @(posedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Offer one request and hold it until taken; maybe idle afterwards.
  task automatic offer(logic [7:0] b, logic ns);
    in_valid <= 1'b1;
    in_byte <= b;
    in_new_string <= ns;
    do @(posedge clk); while (!in_ready);
    if (!quiet && sender_idles && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_text();
    foreach (text[i]) offer(text[i], i == 0);
  endtask

  // Drop valid and wait until every expected result has been seen.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    if ($urandom_range(0, 1) == 1) return 8'h41 + 8'(v) - 8'd10;
    return 8'h61 + 8'(v) - 8'd10;
  endfunction

  function automatic bit is_hex(logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  function automatic bit is_escape_char(logic [7:0] b);
    case (b)
      CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void put_u(logic [15:0] v);
    text.push_back(CH_BSLASH);
    text.push_back(CH_U);
    for (int i = 3; i >= 0; i--) text.push_back(hex_char(v[i*4 +: 4]));
  endfunction

  // Code point outside the surrogate range, spread over the one-, two- and three-byte UTF-8 lengths.
  function automatic logic [15:0] pick_bmp();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(16'h0000, 16'h007F));
      1: return 16'($urandom_range(16'h0080, 16'h07FF));
      2: return 16'($urandom_range(16'h0800, 16'hD7FF));
      default: return 16'($urandom_range(16'hE000, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(32, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  // Nonzero byte other than avoid; if asked, no hex digit or no escape character.
  function automatic logic [7:0] other_byte(logic [7:0] avoid, bit no_hex, bit no_esc);
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == avoid || (no_hex && is_hex(b)) || (no_esc && is_escape_char(b)));
    return b;
  endfunction

  function automatic void put_digits(int n);
    repeat (n) text.push_back(hex_char(4'($urandom_range(0, 15))));
  endfunction

  // Mostly well formed strings with random content; two fifths end in a fault
  // or are cut off by the next string.
  function automatic void build_string();
    logic [7:0] simple[8];
    bit closed;
    simple = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
    closed = 1'b1;
    text.delete();
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: text.push_back(plain_byte());
        4, 5: begin
          text.push_back(CH_BSLASH);
          text.push_back(simple[$urandom_range(0, 7)]);
        end
        6, 7: put_u(pick_bmp());
        default: begin
          put_u(16'($urandom_range(16'hD800, 16'hDBFF)));
          put_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end
      endcase
    end
    case ($urandom_range(0, 19))
      12: text.push_back(8'($urandom_range(1, 31)));
      13: begin
        // end of input, sometimes in the middle of an escape
        if ($urandom_range(0, 1) == 1) text.push_back(CH_BSLASH);
        text.push_back(8'h00);
      end
      14: begin
        text.push_back(CH_BSLASH);
        text.push_back(other_byte(CH_U, 1'b0, 1'b1));
      end
      15: begin
        if ($urandom_range(0, 1) == 1) put_u(16'($urandom_range(16'hD800, 16'hDBFF)));
        text.push_back(CH_BSLASH);
        text.push_back(CH_U);
        put_digits($urandom_range(0, 3));
        text.push_back(other_byte(8'h30, 1'b1, 1'b0));
      end
      16: begin
        // high surrogate not followed by backslash and u
        put_u(16'($urandom_range(16'hD800, 16'hDBFF)));
        if ($urandom_range(0, 1) == 1) begin
          text.push_back(other_byte(CH_BSLASH, 1'b0, 1'b0));
        end else begin
          text.push_back(CH_BSLASH);
          text.push_back(other_byte(CH_U, 1'b0, 1'b0));
        end
      end
      17: begin
        put_u(16'($urandom_range(16'hD800, 16'hDBFF)));
        if ($urandom_range(0, 1) == 1) put_u(pick_bmp());
        else put_u(16'($urandom_range(16'hD800, 16'hDBFF)));
      end
      18: put_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
      19: begin
        // cut off; the next new string has to clear the state
        closed = 1'b0;
        case ($urandom_range(0, 2))
          0: text.push_back(CH_BSLASH);
          1: begin
            text.push_back(CH_BSLASH);
            text.push_back(CH_U);
            put_digits($urandom_range(1, 3));
          end
          default: put_u(16'($urandom_range(16'hD800, 16'hDBFF)));
        endcase
      end
      default: text.push_back(CH_QUOTE);
    endcase
    body_len = text.size();
    // Trailing bytes after an end or error must be dropped by the block.
    if (closed) repeat ($urandom_range(0, 2)) text.push_back(8'($urandom_range(0, 255)));
  endfunction

  initial begin
    int sent;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Escaped zero, top plain byte, escaped newline, then a control byte.
    text = '{CH_BSLASH, CH_U, 8'h30, 8'h30, 8'h30, 8'h30, 8'hFF, CH_BSLASH, CH_N, 8'h1F};
    send_text();
    // Zero byte as the very first byte of a string.
    text = '{8'h00};
    send_text();
    // Largest surrogate pair (U+10FFFF), closing quote, one ignored byte.
    text = '{CH_BSLASH, CH_U, 8'h44, 8'h42, 8'h46, 8'h46,
             CH_BSLASH, CH_U, 8'h64, 8'h66, 8'h66, 8'h66, CH_QUOTE, 8'h7E};
    send_text();
    wait_drained();

    // Stall the receiver for long while plain bytes keep coming so that the
    // result queue fills and the input side is held off.
    long_hold = 1'b1;
    sender_idles = 1'b0;
    text.delete();
    repeat (30) text.push_back(plain_byte());
    send_text();
    wait_drained();

    sent = 55;  // requests of the directed strings above
    while (sent < 280) begin
      if (sent >= 240) quiet = 1'b1;
      sender_idles = $urandom_range(0, 2) != 0;
      build_string();
      send_text();
      sent += body_len;
      if (!quiet && $urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    // Catch any stray result after the last expected one.
    repeat (20) @(posedge clk);
    if (sb.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
